/* hdl/pfit_pkg.sv */
package pfit_pkg;

    // input format
    localparam int IN_W   = 24;
    localparam int FRAC_W = 16;
    localparam int NFIELD = 9;

    // corner differences and their products
    localparam int DIF_W  = IN_W + 1;
    localparam int PRD_W  = 2 * DIF_W;
    // determinant and slope numerators
    localparam int DET_W  = PRD_W + 1;
    // split of a det-wide operand for the constant-term products
    localparam int LO_W   = DET_W / 2;
    localparam int HI_W   = DET_W - LO_W;
    // constant-term numerator
    localparam int NA_W   = IN_W + DET_W + 2;
    localparam int NBS_W  = DET_W + FRAC_W;
    localparam int NUM_W  = (NA_W > NBS_W) ? NA_W : NBS_W;

    // divider
    localparam int OUT_W  = 32;
    localparam int QB     = OUT_W + 1;
    localparam int D2_W   = DET_W + 1;
    localparam int REM_A  = D2_W + QB;
    localparam int REM_B  = NUM_W + 2;
    localparam int REM_W  = (REM_A > REM_B) ? REM_A : REM_B;

    localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (OUT_W - 1));

    // bus widths
    localparam int S_DATA_W = NFIELD * IN_W;
    localparam int M_DATA_W = 3 * OUT_W;

    typedef logic signed [IN_W-1:0]  in_t;
    typedef logic signed [DET_W-1:0] det_t;
    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic signed [OUT_W-1:0] coef_t;

endpackage

/* hdl/pfit_coef.sv */
module pfit_coef (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_vld,
    output logic            in_rdy,
    input  pfit_pkg::in_t   x0,
    input  pfit_pkg::in_t   y0,
    input  pfit_pkg::in_t   x1,
    input  pfit_pkg::in_t   y1,
    input  pfit_pkg::in_t   x2,
    input  pfit_pkg::in_t   y2,
    input  pfit_pkg::in_t   f0,
    input  pfit_pkg::in_t   f1,
    input  pfit_pkg::in_t   f2,
    output logic            out_vld,
    output pfit_pkg::det_t  det,
    output pfit_pkg::num_t  num_a,
    output pfit_pkg::num_t  num_b,
    output pfit_pkg::num_t  num_c
);
    import pfit_pkg::*;

    typedef logic signed [DIF_W-1:0] dif_t;
    typedef logic signed [PRD_W-1:0] prd_t;
    typedef logic signed [IN_W+LO_W:0]   pl_t;
    typedef logic signed [IN_W+HI_W-1:0] ph_t;
    typedef logic signed [NA_W-1:0]  na_t;

    logic [5:0] vld_reg;
    logic       ld0;

    // S0: differences
    dif_t dx1_reg, dy1_reg, dx2_reg, dy2_reg, df1_reg, df2_reg;
    in_t  x0_s0_reg, y0_s0_reg, f0_s0_reg;
    // S1: products
    prd_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    in_t  x0_s1_reg, y0_s1_reg, f0_s1_reg;
    // S2: det and slope numerators
    det_t d_s2_reg, nb_s2_reg, nc_s2_reg;
    in_t  x0_s2_reg, y0_s2_reg, f0_s2_reg;
    // S3: split partial products
    pl_t  fl_reg, xl_reg, yl_reg;
    ph_t  fh_reg, xh_reg, yh_reg;
    det_t d_s3_reg, nb_s3_reg, nc_s3_reg;
    // S4: full products
    na_t  tf_reg, tx_reg, ty_reg;
    det_t d_s4_reg, nb_s4_reg, nc_s4_reg;
    // S5: constant-term numerator
    na_t  na_reg;
    det_t d_s5_reg, nb_s5_reg, nc_s5_reg;

    assign ld0    = adv | ~vld_reg[0];
    assign in_rdy = ld0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld0) begin
                vld_reg[0] <= in_vld;
            end
            if (adv) begin
                vld_reg[5:1] <= vld_reg[4:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            dx1_reg   <= DIF_W'(x1) - DIF_W'(x0);
            dy1_reg   <= DIF_W'(y1) - DIF_W'(y0);
            dx2_reg   <= DIF_W'(x2) - DIF_W'(x0);
            dy2_reg   <= DIF_W'(y2) - DIF_W'(y0);
            df1_reg   <= DIF_W'(f1) - DIF_W'(f0);
            df2_reg   <= DIF_W'(f2) - DIF_W'(f0);
            x0_s0_reg <= x0;
            y0_s0_reg <= y0;
            f0_s0_reg <= f0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg    <= dx1_reg * dy2_reg;
            p2_reg    <= dx2_reg * dy1_reg;
            p3_reg    <= df1_reg * dy2_reg;
            p4_reg    <= df2_reg * dy1_reg;
            p5_reg    <= dx1_reg * df2_reg;
            p6_reg    <= dx2_reg * df1_reg;
            x0_s1_reg <= x0_s0_reg;
            y0_s1_reg <= y0_s0_reg;
            f0_s1_reg <= f0_s0_reg;

            d_s2_reg  <= DET_W'(p1_reg) - DET_W'(p2_reg);
            nb_s2_reg <= DET_W'(p3_reg) - DET_W'(p4_reg);
            nc_s2_reg <= DET_W'(p5_reg) - DET_W'(p6_reg);
            x0_s2_reg <= x0_s1_reg;
            y0_s2_reg <= y0_s1_reg;
            f0_s2_reg <= f0_s1_reg;

            // low half unsigned, high half signed
            fl_reg    <= f0_s2_reg * $signed({1'b0, d_s2_reg[LO_W-1:0]});
            fh_reg    <= f0_s2_reg * $signed(d_s2_reg[DET_W-1:LO_W]);
            xl_reg    <= x0_s2_reg * $signed({1'b0, nb_s2_reg[LO_W-1:0]});
            xh_reg    <= x0_s2_reg * $signed(nb_s2_reg[DET_W-1:LO_W]);
            yl_reg    <= y0_s2_reg * $signed({1'b0, nc_s2_reg[LO_W-1:0]});
            yh_reg    <= y0_s2_reg * $signed(nc_s2_reg[DET_W-1:LO_W]);
            d_s3_reg  <= d_s2_reg;
            nb_s3_reg <= nb_s2_reg;
            nc_s3_reg <= nc_s2_reg;

            tf_reg    <= (NA_W'(fh_reg) <<< LO_W) + NA_W'(fl_reg);
            tx_reg    <= (NA_W'(xh_reg) <<< LO_W) + NA_W'(xl_reg);
            ty_reg    <= (NA_W'(yh_reg) <<< LO_W) + NA_W'(yl_reg);
            d_s4_reg  <= d_s3_reg;
            nb_s4_reg <= nb_s3_reg;
            nc_s4_reg <= nc_s3_reg;

            na_reg    <= tf_reg - tx_reg - ty_reg;
            d_s5_reg  <= d_s4_reg;
            nb_s5_reg <= nb_s4_reg;
            nc_s5_reg <= nc_s4_reg;
        end
    end

    assign out_vld = vld_reg[5];
    assign det     = d_s5_reg;
    assign num_a   = NUM_W'(na_reg);
    assign num_b   = NUM_W'($signed({nb_s5_reg, {FRAC_W{1'b0}}}));
    assign num_c   = NUM_W'($signed({nc_s5_reg, {FRAC_W{1'b0}}}));

endmodule

/* hdl/pfit_div.sv */
module pfit_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_vld,
    input  pfit_pkg::num_t  num,
    input  pfit_pkg::det_t  den,
    output logic            out_vld,
    output logic            out_sing,
    output pfit_pkg::coef_t quo
);
    import pfit_pkg::*;

    // A: magnitudes
    logic               vld_a_reg, neg_a_reg, sing_a_reg;
    logic [NUM_W-1:0]   nm_reg;
    logic [DET_W-1:0]   dm_reg;
    // B: rounding offset, doubled divisor
    logic               vld_b_reg, neg_b_reg, sing_b_reg;
    logic [REM_W-1:0]   n2_reg;
    logic [D2_W-1:0]    d2_b_reg;
    // steps: index 0 is the overflow-check stage
    logic               vld_reg  [0:QB];
    logic               neg_reg  [0:QB];
    logic               sing_reg [0:QB];
    logic               ovf_reg  [0:QB];
    logic [REM_W-1:0]   rem_reg  [0:QB];
    logic [QB-1:0]      q_reg    [0:QB];
    logic [D2_W-1:0]    d2_reg   [0:QB];
    // F: saturate
    logic               vld_f_reg, sing_f_reg;
    coef_t              quo_reg;
    logic [QB-1:0]      lim;
    logic [QB-1:0]      mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
            vld_f_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg  <= in_vld;
            vld_b_reg  <= vld_a_reg;
            vld_reg[0] <= vld_b_reg;
            vld_f_reg  <= vld_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg_a_reg  <= num[NUM_W-1] ^ den[DET_W-1];
            sing_a_reg <= (den == '0);
            nm_reg     <= num[NUM_W-1] ? (~num + 1'b1) : num;
            dm_reg     <= den[DET_W-1] ? (~den + 1'b1) : den;

            neg_b_reg  <= neg_a_reg;
            sing_b_reg <= sing_a_reg;
            n2_reg     <= (REM_W'(nm_reg) << 1) + REM_W'(dm_reg);
            d2_b_reg   <= {dm_reg, 1'b0};

            neg_reg[0]  <= neg_b_reg;
            sing_reg[0] <= sing_b_reg;
            ovf_reg[0]  <= n2_reg >= (REM_W'(d2_b_reg) << QB);
            rem_reg[0]  <= n2_reg;
            q_reg[0]    <= '0;
            d2_reg[0]   <= d2_b_reg;
        end
    end

    for (genvar i = 0; i < QB; i++) begin : g_step
        localparam int K = QB - 1 - i;
        logic [REM_W-1:0] sh;
        logic             ge;
        assign sh = REM_W'(d2_reg[i]) << K;
        assign ge = rem_reg[i] >= sh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                neg_reg[i+1]  <= neg_reg[i];
                sing_reg[i+1] <= sing_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                d2_reg[i+1]   <= d2_reg[i];
                rem_reg[i+1]  <= ge ? (rem_reg[i] - sh) : rem_reg[i];
                q_reg[i+1]    <= q_reg[i] | (ge ? (QB'(1) << K) : '0);
            end
        end
    end

    always_comb begin
        lim = neg_reg[QB] ? LIM_NEG : LIM_POS;
        mag = (ovf_reg[QB] || q_reg[QB] > lim) ? lim : q_reg[QB];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sing_f_reg <= sing_reg[QB];
            if (sing_reg[QB]) begin
                quo_reg <= '0;
            end else if (neg_reg[QB]) begin
                quo_reg <= OUT_W'(~mag + 1'b1);
            end else begin
                quo_reg <= OUT_W'(mag);
            end
        end
    end

    assign out_vld  = vld_f_reg;
    assign out_sing = sing_f_reg;
    assign quo      = quo_reg;

endmodule

/* hdl/plane_fit_three_points.sv */
// Plane fit through three triangle corners: for each beat of nine signed Q8.16
// words (corners and corner values) the block returns the Q16.16 coefficients
// of f = a + b*x + c*y, rounded to nearest with ties away from zero and
// saturated to 32 bits; a zero determinant sets m_tuser and zeroes all three.
// The pipeline takes one beat per clock while it advances: 6 stages form the
// determinant and the numerators, and then three parallel restoring dividers
// of 37 stages each (one quotient bit per stage over 33 bits) form the
// coefficients. The whole pipeline advances while the
// output register is empty or being read; the first stage also fills while
// empty, so a waiting result does not block a new beat from entering.
module plane_fit_three_points (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // node0_x, node0_y, node1_x, node1_y, node2_x, node2_y, value0, value1, value2
    input  logic [pfit_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // coef_const, coef_x, coef_y
    output logic [pfit_pkg::M_DATA_W-1:0]  m_tdata,
    // singular
    output logic                           m_tuser
);
    import pfit_pkg::*;

    logic  adv;
    logic  c_vld;
    det_t  det;
    num_t  num_a, num_b, num_c;
    coef_t coef_const, coef_x, coef_y;
    logic  vld_a, vld_b, vld_c;
    logic  sing_a, sing_b, sing_c;

    // global advance: output register free or drained this cycle
    assign adv = ~m_tvalid | m_tready;

    pfit_coef u_coef (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (s_tvalid),
        .in_rdy  (s_tready),
        .x0      (s_tdata[0*IN_W +: IN_W]),
        .y0      (s_tdata[1*IN_W +: IN_W]),
        .x1      (s_tdata[2*IN_W +: IN_W]),
        .y1      (s_tdata[3*IN_W +: IN_W]),
        .x2      (s_tdata[4*IN_W +: IN_W]),
        .y2      (s_tdata[5*IN_W +: IN_W]),
        .f0      (s_tdata[6*IN_W +: IN_W]),
        .f1      (s_tdata[7*IN_W +: IN_W]),
        .f2      (s_tdata[8*IN_W +: IN_W]),
        .out_vld (c_vld),
        .det     (det),
        .num_a   (num_a),
        .num_b   (num_b),
        .num_c   (num_c)
    );

    // constant term
    pfit_div u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (c_vld),
        .num      (num_a),
        .den      (det),
        .out_vld  (vld_a),
        .out_sing (sing_a),
        .quo      (coef_const)
    );

    // x slope
    pfit_div u_div_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (c_vld),
        .num      (num_b),
        .den      (det),
        .out_vld  (vld_b),
        .out_sing (sing_b),
        .quo      (coef_x)
    );

    // y slope
    pfit_div u_div_c (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (c_vld),
        .num      (num_c),
        .den      (det),
        .out_vld  (vld_c),
        .out_sing (sing_c),
        .quo      (coef_y)
    );

    // the three lanes run in lockstep
    assign m_tvalid = vld_a & vld_b & vld_c;
    assign m_tuser  = sing_a & sing_b & sing_c;
    assign m_tdata  = {coef_y, coef_x, coef_const};

endmodule

/* hdl/pfit_chk.sv */
module pfit_chk (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pfit_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pfit_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           m_tuser
);
    import pfit_pkg::*;

    // pipeline empties on reset
    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // degenerate triangle gives zero coefficients
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("singular result with nonzero coefficients");

    // an empty output register never blocks input
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind plane_fit_three_points pfit_chk u_pfit_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
